FILE: rtl/bced_pkg.sv
// bced_pkg: shared types and constants for the button click event detector
// no dependencies; imported by the scan and cfg interfaces and every rtl module

package bced_pkg;

    localparam int TICK_W  = 32;
    localparam int TIME_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        PRESS_NONE = 2'd0,
        PRESS_DOWN = 2'd1,
        PRESS_LONG = 2'd2
    } press_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 2'd0,
        REG_CLICK_INTERVAL = 2'd1,
        REG_LONG_PRESS     = 2'd2,
        REG_DOUBLE_CLICK   = 2'd3
    } cfg_index_t;

    localparam logic [TIME_W-1:0] CLICK_INTERVAL_RST = 16'd300;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST     = 16'd1000;
    localparam logic [TIME_W-1:0] DOUBLE_CLICK_RST   = 16'd200;

    typedef struct packed {
        logic              enable;
        logic [TIME_W-1:0] click_interval_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] double_click_ms;
    } bced_cfg_t;

    typedef struct packed {
        press_state_t      press_state;
        logic              click_pending;
        logic              long_reported;
        logic [TICK_W-1:0] press_time;
        logic [TICK_W-1:0] release_time;
    } bced_state_t;

    typedef struct packed {
        logic short_click;
        logic long_press;
        logic double_click;
    } bced_flags_t;

endpackage

FILE: rtl/bced_if.sv
// bced interfaces: scan input, event result and configuration write channels
// depends on bced_pkg for field widths

interface bced_scan_if;
    import bced_pkg::*;
    logic              valid;
    logic              ready;
    logic              pressed;
    logic [TICK_W-1:0] now_ms;
    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface bced_result_if;
    logic valid;
    logic ready;
    logic short_click;
    logic long_press;
    logic double_click;
    modport source (output valid, output short_click, output long_press,
                    output double_click, input ready);
    modport sink   (input valid, input short_click, input long_press,
                    input double_click, output ready);
endinterface

interface bced_cfg_if;
    import bced_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/button_click_event_detector_unit.sv
// button_click_event_detector_unit: top level with scan register, state and result register
// depends on bced_pkg, bced_if, bced_cfg_regs and bced_eval
// path: a transferred scan is held in the scan register, then evaluated into the state and result registers
// throughput: one scan per cycle while result.ready is high, set by the single state update per scan
// reset: config registers at their default values, valids cleared, detector idle with no press seen

module button_click_event_detector_unit (
    input  logic           clk,
    input  logic           rst_n,
    bced_scan_if.sink      scan,
    bced_result_if.source  result,
    bced_cfg_if.sink       cfg
);
    import bced_pkg::*;

    bced_cfg_t         cfg_val;
    bced_state_t       state_reg;
    bced_state_t       state_next;
    bced_flags_t       flags_reg;
    bced_flags_t       flags_next;
    logic              scan_valid_reg;
    logic              scan_pressed_reg;
    logic [TICK_W-1:0] scan_now_reg;
    logic              res_valid_reg;
    logic              advance;
    logic              fire;

    bced_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    bced_eval u_eval (
        .cfg_val (cfg_val),
        .cur     (state_reg),
        .pressed (scan_pressed_reg),
        .now_ms  (scan_now_reg),
        .nxt     (state_next),
        .flags   (flags_next)
    );

    assign advance    = !res_valid_reg || result.ready;
    assign fire       = scan_valid_reg && advance;
    assign scan.ready = !scan_valid_reg || advance;

    assign result.valid        = res_valid_reg;
    assign result.short_click  = flags_reg.short_click;
    assign result.long_press   = flags_reg.long_press;
    assign result.double_click = flags_reg.double_click;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '{PRESS_NONE, 1'b0, 1'b0, '0, '0};
        end
        else
        begin
            if (scan.valid && scan.ready)
                scan_valid_reg <= 1'b1;
            else if (fire)
                scan_valid_reg <= 1'b0;
            if (advance)
                res_valid_reg <= scan_valid_reg;
            if (fire)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            scan_pressed_reg <= scan.pressed;
            scan_now_reg     <= scan.now_ms;
        end
        if (fire)
            flags_reg <= flags_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(flags_reg.long_press && flags_reg.double_click))
        else $error("long press and double click in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !cfg_val.enable) |=>
        !(flags_reg.short_click || flags_reg.long_press || flags_reg.double_click))
        else $error("event reported while disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.press_state == PRESS_NONE |-> !state_reg.long_reported)
        else $error("long press flag left set after release");

endmodule

FILE: rtl/bced_cfg_regs.sv
// bced_cfg_regs: configuration register file written over the cfg channel
// depends on bced_pkg and bced_cfg_if

module bced_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    bced_cfg_if.sink           cfg,
    output bced_pkg::bced_cfg_t cfg_val
);
    import bced_pkg::*;

    bced_cfg_t cfg_reg;
    logic      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign cfg_val   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.click_interval_ms <= CLICK_INTERVAL_RST;
            cfg_reg.long_press_ms     <= LONG_PRESS_RST;
            cfg_reg.double_click_ms   <= DOUBLE_CLICK_RST;
        end
        else if (wr)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_ENABLE:         cfg_reg.enable            <= cfg.data[0];
                REG_CLICK_INTERVAL: cfg_reg.click_interval_ms <= cfg.data;
                REG_LONG_PRESS:     cfg_reg.long_press_ms     <= cfg.data;
                REG_DOUBLE_CLICK:   cfg_reg.double_click_ms   <= cfg.data;
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: rtl/bced_eval.sv
// bced_eval: per-scan event logic, next detector state and event flags
// depends on bced_pkg

module bced_eval (
    input  bced_pkg::bced_cfg_t                 cfg_val,
    input  bced_pkg::bced_state_t               cur,
    input  logic                                pressed,
    input  logic [bced_pkg::TICK_W-1:0]         now_ms,
    output bced_pkg::bced_state_t               nxt,
    output bced_pkg::bced_flags_t               flags
);
    import bced_pkg::*;

    logic [TICK_W-1:0] since_press;
    logic [TICK_W-1:0] since_release;
    logic [TICK_W-1:0] press_time_new;

    always_comb
    begin
        nxt            = cur;
        flags          = '0;
        press_time_new = (pressed && cur.press_state == PRESS_NONE) ? now_ms
                                                                    : cur.press_time;
        since_press    = now_ms - press_time_new;
        since_release  = now_ms - cur.release_time;
        if (cfg_val.enable)
        begin
            if (pressed && cur.press_state == PRESS_NONE)
            begin
                nxt.press_state = PRESS_DOWN;
                nxt.press_time  = now_ms;
            end
            if (cur.click_pending &&
                since_press >= {{(TICK_W-TIME_W){1'b0}}, cfg_val.click_interval_ms})
            begin
                nxt.click_pending = 1'b0;
                flags.short_click = 1'b1;
            end
            if (pressed)
            begin
                if (since_press >= {{(TICK_W-TIME_W){1'b0}}, cfg_val.long_press_ms})
                begin
                    nxt.press_state   = PRESS_LONG;
                    nxt.long_reported = 1'b1;
                    flags.long_press  = !cur.long_reported;
                end
            end
            else if (cur.press_state != PRESS_NONE)
            begin
                nxt.press_state   = PRESS_NONE;
                nxt.long_reported = 1'b0;
                nxt.release_time  = now_ms;
                if (since_release <= {{(TICK_W-TIME_W){1'b0}}, cfg_val.double_click_ms})
                begin
                    flags.double_click = 1'b1;
                    nxt.click_pending  = 1'b0;
                end
                else if (since_press <=
                         {{(TICK_W-TIME_W){1'b0}}, cfg_val.long_press_ms})
                begin
                    nxt.click_pending = 1'b1;
                end
            end
        end
    end

endmodule
